// ===== rtl/lvg_pkg.sv =====
// Shared types, constants and the arctangent table of the lathe vertex generator.
`default_nettype none
package lvg_pkg;

	localparam int MAX_SEGMENTS = 128;
	localparam int MAX_POINTS   = 1024;
	localparam int CORDIC_STEPS = 16;

	// Divider lanes: ring angle, texture u, texture v
	localparam int DIV_W  = 26;
	localparam int DEN_W  = 10;
	localparam int LANES  = 3;
	localparam int ANG_W  = 34;

	localparam logic [16:0] FULL_TURN        = 17'd65536;
	localparam logic [16:0] SEAM_LEN_MIN     = 17'd65432;
	localparam logic [7:0]  DEFAULT_SEGMENTS = 8'd6;
	localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Register indexes of the configuration port
	localparam logic [2:0] CFG_SEGMENT_COUNT = 3'd0;
	localparam logic [2:0] CFG_ANGLE_START   = 3'd1;
	localparam logic [2:0] CFG_ANGLE_LENGTH  = 3'd2;
	localparam logic [2:0] CFG_PROFILE_COUNT = 3'd3;
	localparam logic [2:0] CFG_CLOSE_SEAM    = 3'd4;

	typedef struct packed {
		logic signed [23:0] profile_x;
		logic signed [23:0] profile_y;
		logic [7:0]         ring_index;
		logic [9:0]         point_index;
	} lvg_in_t;

	typedef struct packed {
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic signed [23:0] vertex_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
	} lvg_out_t;

	// Arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
		logic signed [ANG_W-1:0] r;
		begin
			case (i)
				0:  r = 34'sd536870912;
				1:  r = 34'sd316933406;
				2:  r = 34'sd167458907;
				3:  r = 34'sd85004756;
				4:  r = 34'sd42667331;
				5:  r = 34'sd21354465;
				6:  r = 34'sd10679838;
				7:  r = 34'sd5340245;
				8:  r = 34'sd2670163;
				9:  r = 34'sd1335087;
				10: r = 34'sd667544;
				11: r = 34'sd333772;
				12: r = 34'sd166886;
				13: r = 34'sd83443;
				14: r = 34'sd41722;
				15: r = 34'sd20861;
				16: r = 34'sd10430;
				17: r = 34'sd5215;
				18: r = 34'sd2608;
				19: r = 34'sd1304;
				20: r = 34'sd652;
				21: r = 34'sd326;
				22: r = 34'sd163;
				23: r = 34'sd81;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lathe_vertex_generator.sv =====
// Top level of the lathe vertex generator: divider, CORDIC and scaling pipeline.
//
// One profile point enters with start; busy is always low, so an item can be
// issued in every clock cycle. The matching vertex appears on result for one
// cycle, marked by done, in issue order. Throughput is one vertex per cycle.
// The pipeline is made of the 26 stages of the bit-per-stage dividers (ring
// angle, texture u, texture v run side by side), the 16 CORDIC rotation
// stages and four stages of set-up, angle fold, multiply and rounding.
// Configuration is written over cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Write only while no vertex is in flight.
// Reset clears the valid bits of the pipeline and loads the register reset
// values (6 segments, start and length 10430, 99 points, seam open).
// The receiver cannot stall: done is a one-cycle strobe and the result must
// be taken in that cycle.
`default_nettype none
module lathe_vertex_generator import lvg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire lvg_in_t     item,
	output logic             done,
	output lvg_out_t         result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	// Configuration registers
	logic [7:0]  seg_cnt_q;
	logic [16:0] ang_start_q;
	logic [16:0] ang_len_q;
	logic [10:0] prof_cnt_q;
	logic        close_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q   <= DEFAULT_SEGMENTS;
			ang_start_q <= 17'd10430;
			ang_len_q   <= 17'd10430;
			prof_cnt_q  <= 11'd99;
			close_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEGMENT_COUNT: seg_cnt_q   <= cfg_data[7:0];
				CFG_ANGLE_START:   ang_start_q <= cfg_data;
				CFG_ANGLE_LENGTH:  ang_len_q   <= cfg_data;
				CFG_PROFILE_COUNT: prof_cnt_q  <= cfg_data[10:0];
				CFG_CLOSE_SEAM:    close_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp configuration into range; the user must keep it static while items are in flight (not enforced here)
	logic [7:0]       seg_eff;
	logic [16:0]      start_c;
	logic [16:0]      len_c;
	logic [10:0]      cnt_c;
	logic             almost;
	logic [DEN_W-1:0] den [0:LANES-1];

	always_comb begin
		if (seg_cnt_q == 8'd0)
			seg_eff = DEFAULT_SEGMENTS;
		else if (seg_cnt_q > 8'(MAX_SEGMENTS))
			seg_eff = 8'(MAX_SEGMENTS);
		else
			seg_eff = seg_cnt_q;
		start_c = (ang_start_q > FULL_TURN) ? FULL_TURN : ang_start_q;
		len_c   = (ang_len_q > FULL_TURN) ? FULL_TURN : ang_len_q;
		if (prof_cnt_q < 11'd2)
			cnt_c = 11'd2;
		else if (prof_cnt_q > 11'(MAX_POINTS))
			cnt_c = 11'(MAX_POINTS);
		else
			cnt_c = prof_cnt_q;
		almost = (len_c >= SEAM_LEN_MIN);
		den[0] = DEN_W'(seg_eff);
		den[1] = DEN_W'(seg_eff);
		den[2] = DEN_W'(cnt_c - 11'd1);
	end

	// Divider pipeline: stage 0 holds the numerators, each stage yields one bit
	logic                     dv_v_s    [0:DIV_W];
	logic [DIV_W-1:0]         dv_nq_s   [0:DIV_W][0:LANES-1];
	logic [DEN_W-1:0]         dv_rm_s   [0:DIV_W][0:LANES-1];
	logic signed [23:0]       dv_px_s   [0:DIV_W];
	logic signed [23:0]       dv_py_s   [0:DIV_W];
	logic                     dv_seam_s [0:DIV_W];

	logic [DIV_W-1:0] num_in [0:LANES-1];
	logic             seam_in;

	always_comb begin
		num_in[0] = DIV_W'(item.ring_index) * DIV_W'(len_c) + DIV_W'(seg_eff >> 1);
		num_in[1] = DIV_W'({item.ring_index, 16'd0}) + DIV_W'(seg_eff >> 1);
		num_in[2] = DIV_W'({item.point_index, 16'd0}) + DIV_W'(den[2] >> 1);
		seam_in   = close_q && almost && (item.ring_index == seg_eff);
	end

	// Advance valid bits through the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_W; k++)
				dv_v_s[k] <= 1'b0;
		end else begin
			dv_v_s[0] <= start && !busy;
			for (int k = 0; k < DIV_W; k++)
				dv_v_s[k+1] <= dv_v_s[k];
		end
	end

	// Restoring division, one quotient bit per stage and lane
	always_ff @(posedge clk) begin
		logic [DEN_W:0] t;
		logic           ge;
		dv_px_s[0]   <= item.profile_x;
		dv_py_s[0]   <= item.profile_y;
		dv_seam_s[0] <= seam_in;
		for (int l = 0; l < LANES; l++) begin
			dv_nq_s[0][l] <= num_in[l];
			dv_rm_s[0][l] <= '0;
		end
		for (int k = 0; k < DIV_W; k++) begin
			dv_px_s[k+1]   <= dv_px_s[k];
			dv_py_s[k+1]   <= dv_py_s[k];
			dv_seam_s[k+1] <= dv_seam_s[k];
			for (int l = 0; l < LANES; l++) begin
				t  = {dv_rm_s[k][l], dv_nq_s[k][l][DIV_W-1]};
				ge = (t >= {1'b0, den[l]});
				dv_rm_s[k+1][l] <= ge ? DEN_W'(t - {1'b0, den[l]}) : t[DEN_W-1:0];
				dv_nq_s[k+1][l] <= {dv_nq_s[k][l][DIV_W-2:0], ge};
			end
		end
	end

	// Form the ring angle, fold it into the half turn around zero, saturate uv
	logic [15:0]             phi16;
	logic [31:0]             a_raw;
	logic [31:0]             a_fold;
	logic                    flip_in;
	logic [16:0]             u_sat;
	logic [16:0]             v_sat;

	always_comb begin
		phi16   = dv_seam_s[DIV_W] ? start_c[15:0]
		                           : start_c[15:0] + dv_nq_s[DIV_W][0][15:0];
		a_raw   = {phi16, 16'd0};
		flip_in = a_raw[31] ^ a_raw[30];
		a_fold  = flip_in ? a_raw - 32'h8000_0000 : a_raw;
		u_sat   = (dv_nq_s[DIV_W][1] > DIV_W'(FULL_TURN)) ? FULL_TURN
		                                                 : dv_nq_s[DIV_W][1][16:0];
		v_sat   = (dv_nq_s[DIV_W][2] > DIV_W'(FULL_TURN)) ? FULL_TURN
		                                                 : dv_nq_s[DIV_W][2][16:0];
	end

	// CORDIC rotation pipeline
	logic                    cr_v_s  [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cr_x_s  [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cr_y_s  [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cr_z_s  [0:CORDIC_STEPS];
	logic                    cr_fl_s [0:CORDIC_STEPS];
	logic signed [23:0]      cr_px_s [0:CORDIC_STEPS];
	logic signed [23:0]      cr_py_s [0:CORDIC_STEPS];
	logic [16:0]             cr_u_s  [0:CORDIC_STEPS];
	logic [16:0]             cr_tv_s [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++)
				cr_v_s[k] <= 1'b0;
		end else begin
			cr_v_s[0] <= dv_v_s[DIV_W];
			for (int k = 0; k < CORDIC_STEPS; k++)
				cr_v_s[k+1] <= cr_v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		cr_x_s[0]  <= CORDIC_GAIN;
		cr_y_s[0]  <= '0;
		cr_z_s[0]  <= ANG_W'($signed(a_fold));
		cr_fl_s[0] <= flip_in;
		cr_px_s[0] <= dv_px_s[DIV_W];
		cr_py_s[0] <= dv_py_s[DIV_W];
		cr_u_s[0]  <= u_sat;
		cr_tv_s[0] <= v_sat;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (!cr_z_s[k][ANG_W-1]) begin
				cr_x_s[k+1] <= cr_x_s[k] - (cr_y_s[k] >>> k);
				cr_y_s[k+1] <= cr_y_s[k] + (cr_x_s[k] >>> k);
				cr_z_s[k+1] <= cr_z_s[k] - atan_turn(k);
			end else begin
				cr_x_s[k+1] <= cr_x_s[k] + (cr_y_s[k] >>> k);
				cr_y_s[k+1] <= cr_y_s[k] - (cr_x_s[k] >>> k);
				cr_z_s[k+1] <= cr_z_s[k] + atan_turn(k);
			end
			cr_fl_s[k+1] <= cr_fl_s[k];
			cr_px_s[k+1] <= cr_px_s[k];
			cr_py_s[k+1] <= cr_py_s[k];
			cr_u_s[k+1]  <= cr_u_s[k];
			cr_tv_s[k+1] <= cr_tv_s[k];
		end
	end

	// Undo the fold and scale the radius by sine and cosine
	logic signed [ANG_W-1:0] sin_f;
	logic signed [ANG_W-1:0] cos_f;
	logic signed [31:0]      sin_t;
	logic signed [31:0]      cos_t;
	logic signed [55:0]      prod_x;
	logic signed [55:0]      prod_z;

	always_comb begin
		sin_f  = cr_fl_s[CORDIC_STEPS] ? -cr_y_s[CORDIC_STEPS] : cr_y_s[CORDIC_STEPS];
		cos_f  = cr_fl_s[CORDIC_STEPS] ? -cr_x_s[CORDIC_STEPS] : cr_x_s[CORDIC_STEPS];
		sin_t  = 32'(sin_f);
		cos_t  = 32'(cos_f);
		prod_x = 56'(cr_px_s[CORDIC_STEPS]) * 56'(sin_t);
		prod_z = 56'(cr_px_s[CORDIC_STEPS]) * 56'(cos_t);
	end

	logic                mp_v_s;
	logic signed [55:0]  mp_x_s;
	logic signed [55:0]  mp_z_s;
	logic signed [23:0]  mp_py_s;
	logic [16:0]         mp_u_s;
	logic [16:0]         mp_tv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mp_v_s <= 1'b0;
		else
			mp_v_s <= cr_v_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		mp_x_s  <= prod_x;
		mp_z_s  <= prod_z;
		mp_py_s <= cr_py_s[CORDIC_STEPS];
		mp_u_s  <= cr_u_s[CORDIC_STEPS];
		mp_tv_s <= cr_tv_s[CORDIC_STEPS];
	end

	// Round to nearest at 2^-30 and saturate to 24 bits
	function automatic logic signed [23:0] round_sat(input logic signed [55:0] p);
		logic signed [55:0] r;
		begin
			r = (p + 56'sd536870912) >>> 30;
			if (r > 56'sd8388607)
				return 24'sd8388607;
			else if (r < -56'sd8388608)
				return -24'sd8388608;
			else
				return 24'(r);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= mp_v_s;
	end

	always_ff @(posedge clk) begin
		result.vertex_x <= round_sat(mp_x_s);
		result.vertex_y <= mp_py_s;
		result.vertex_z <= round_sat(mp_z_s);
		result.tex_u    <= mp_u_s;
		result.tex_v    <= mp_tv_s;
	end

endmodule
`default_nettype wire
